// ===== design/ilir_pkg.sv =====
// shared types, codes and defaults for the indexed list block
package ilir_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int ELEM_WIDTH_DEF = 32;
	// width of positions and counts inside the block, wide enough for the largest capacity
	localparam int IDX_W          = 11;

	// request commands
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_REMOVE  = 2'd1;
	localparam logic [1:0] CMD_APPEND  = 2'd2;
	localparam logic [1:0] CMD_PREPEND = 2'd3;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// shift operations broadcast to the cells
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [6:0]  position;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] removed_value;
		logic [6:0]  count;
	} resp_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pos;
	} shift_ctl_t;

endpackage

// ===== design/indexed_list_insert_remove.sv =====
// top level of the indexed list: a chain of shifting cells with a registered response
//
// usage
//   request channel req_valid / req_ready / req carries cmd, position and value;
//   response channel rsp_valid / rsp_ready / rsp carries status, removed_value
//   and count. every request gives exactly one response.
//   a request is taken whenever the response register is empty or being drained,
//   so one request a cycle is sustained while the receiver keeps up: every cell
//   shifts in the same cycle, wherever in the list the insert or remove falls.
//   the response is registered: it appears in the cycle after acceptance
//   and sits in the response register until rsp_ready is seen.
//   the removed value is picked from the one cell being removed, through an or
//   of the cell taps; that select over CAPACITY cells sets the clock path.
//   if the receiver stalls, the response register holds and req_ready drops,
//   so no response is lost and no request is taken meanwhile.
//   reset clears the element count and the response valid; cell contents are
//   left as they are, since only cells below the count are ever read.
module indexed_list_insert_remove #(
	parameter int CAPACITY   = ilir_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = ilir_pkg::ELEM_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ilir_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ilir_pkg::resp_t rsp
);

	logic                  accept;
	ilir_pkg::shift_ctl_t  ctl;
	logic [1:0]            status;
	logic [6:0]            count_after;
	logic [ELEM_WIDTH-1:0] ins_value;
	logic [ELEM_WIDTH-1:0] entries [CAPACITY];
	logic [ELEM_WIDTH-1:0] taps [CAPACITY];
	logic [ELEM_WIDTH-1:0] removed_elem;
	logic [31:0]           removed_word;
	logic                  rsp_valid_q;
	ilir_pkg::resp_t       rsp_q;

	// handshake: the response register parts the two sides
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	ilir_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.accept     (accept),
		.ctl        (ctl),
		.status     (status),
		.count_after(count_after)
	);

	// value bits above the element width are dropped on store
	generate
		if (ELEM_WIDTH <= 32) begin : g_val_narrow
			assign ins_value = req.value[ELEM_WIDTH-1:0];
		end else begin : g_val_wide
			assign ins_value = ELEM_WIDTH'(req.value);
		end
	endgenerate

	// chain of cells, each fed by its neighbours; the ends see zero
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ELEM_WIDTH-1:0] left_nb;
			logic [ELEM_WIDTH-1:0] right_nb;

			if (i == 0) begin : g_first
				assign left_nb = '0;
			end else begin : g_mid_l
				assign left_nb = entries[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign right_nb = '0;
			end else begin : g_mid_r
				assign right_nb = entries[i+1];
			end

			ilir_cell #(
				.ELEM_WIDTH(ELEM_WIDTH),
				.INDEX     (i)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.ins_value(ins_value),
				.left     (left_nb),
				.right    (right_nb),
				.entry    (entries[i]),
				.tap      (taps[i])
			);
		end
	endgenerate

	// at most one tap is non-zero, so an or gives the removed element
	always_comb begin
		removed_elem = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed_elem = removed_elem | taps[i];
		end
	end

	generate
		if (ELEM_WIDTH >= 32) begin : g_rem_narrow
			assign removed_word = removed_elem[31:0];
		end else begin : g_rem_wide
			assign removed_word = 32'(removed_elem);
		end
	endgenerate

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.removed_value <= removed_word;
			rsp_q.count         <= count_after;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/ilir_cell.sv =====
// one storage cell of the list chain
module ilir_cell #(
	parameter int ELEM_WIDTH = ilir_pkg::ELEM_WIDTH_DEF,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  ilir_pkg::shift_ctl_t   ctl,
	input  logic [ELEM_WIDTH-1:0]  ins_value,
	input  logic [ELEM_WIDTH-1:0]  left,
	input  logic [ELEM_WIDTH-1:0]  right,
	output logic [ELEM_WIDTH-1:0]  entry,
	output logic [ELEM_WIDTH-1:0]  tap
);

	localparam logic [ilir_pkg::IDX_W-1:0] IDX = ilir_pkg::IDX_W'(INDEX);

	logic [ELEM_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ilir_pkg::OP_INSERT: begin
				if (ctl.pos == IDX) begin
					entry_q <= ins_value;
				end else if (ctl.pos < IDX) begin
					entry_q <= left;
				end
			end
			ilir_pkg::OP_REMOVE: begin
				if (ctl.pos <= IDX) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	// only the cell being removed drives its value onto the tap
	assign tap = (ctl.op == ilir_pkg::OP_REMOVE && ctl.pos == IDX) ? entry_q : '0;

endmodule

// ===== design/ilir_ctrl.sv =====
// command decode, range and full checks, and the element count
module ilir_ctrl #(
	parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ilir_pkg::req_t       req,
	input  logic                 accept,
	output ilir_pkg::shift_ctl_t ctl,
	output logic [1:0]           status,
	output logic [6:0]           count_after
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           count_next;
	logic [ilir_pkg::IDX_W-1:0] pos_w;
	logic [ilir_pkg::IDX_W-1:0] occ_w;
	logic [ilir_pkg::IDX_W-1:0] cnt_ext;
	logic                       full;
	logic [1:0]                 op;
	logic [ilir_pkg::IDX_W-1:0] op_pos;

	assign pos_w = ilir_pkg::IDX_W'(req.position);
	assign occ_w = ilir_pkg::IDX_W'(count_q);
	assign full  = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		status = ilir_pkg::ST_OK;
		op     = ilir_pkg::OP_HOLD;
		op_pos = '0;
		case (req.cmd)
			ilir_pkg::CMD_INSERT: begin
				if (pos_w > occ_w) begin
					status = ilir_pkg::ST_RANGE;
				end else if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					op     = ilir_pkg::OP_INSERT;
					op_pos = pos_w;
				end
			end
			ilir_pkg::CMD_REMOVE: begin
				if (pos_w >= occ_w) begin
					status = ilir_pkg::ST_RANGE;
				end else begin
					op     = ilir_pkg::OP_REMOVE;
					op_pos = pos_w;
				end
			end
			ilir_pkg::CMD_APPEND: begin
				if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					op     = ilir_pkg::OP_INSERT;
					op_pos = occ_w;
				end
			end
			default: begin
				if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					op     = ilir_pkg::OP_INSERT;
					op_pos = '0;
				end
			end
		endcase
	end

	always_comb begin
		case (op)
			ilir_pkg::OP_INSERT: count_next = count_q + CNT_W'(1);
			ilir_pkg::OP_REMOVE: count_next = count_q - CNT_W'(1);
			default:             count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	assign cnt_ext     = ilir_pkg::IDX_W'(count_next);
	assign count_after = cnt_ext[6:0];
	// cells only move on an accepted request
	assign ctl.op      = accept ? op : ilir_pkg::OP_HOLD;
	assign ctl.pos     = op_pos;

endmodule

// ===== sim/tb_indexed_list_insert_remove.sv =====
// self-checking testbench for the indexed list with insert, remove, append and prepend
`timescale 1ns / 100ps

module tb_indexed_list_insert_remove;
	import ilir_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int N_RANDOM     = 1530;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_PCT     = 16;
	localparam int DRAIN_CYCLES = 4;

	// mirror of the list contents plus the responses still owed by the block
	class list_mirror;
		logic [31:0] cells [CAP];
		int unsigned occupancy;
		resp_t       owed_rsp [$];
		int unsigned errors;
		int unsigned n_checked;
		int unsigned n_ok;
		int unsigned n_range;
		int unsigned n_full;
		int unsigned n_removed;
		int unsigned peak;

		function new();
			occupancy = 0;
			errors    = 0;
			n_checked = 0;
			n_ok      = 0;
			n_range   = 0;
			n_full    = 0;
			n_removed = 0;
			peak      = 0;
		endfunction

		function void make_room(int unsigned at, logic [31:0] v);
			for (int unsigned i = occupancy; i > at; i--)
				cells[i] = cells[i - 1];
			cells[at] = v;
			occupancy++;
		endfunction

		function logic [31:0] take_out(int unsigned at);
			logic [31:0] gone;
			gone = cells[at];
			for (int unsigned i = at; i + 1 < occupancy; i++)
				cells[i] = cells[i + 1];
			occupancy--;
			return gone;
		endfunction

		// apply one accepted request and queue the response it must give
		function void note_request(req_t r);
			resp_t want;
			bit    full;
			want        = '0;
			want.status = ST_OK;
			full        = occupancy >= CAP;
			case (r.cmd)
				CMD_INSERT: begin
					// position is checked before fullness
					if (r.position > occupancy)
						want.status = ST_RANGE;
					else if (full)
						want.status = ST_FULL;
					else
						make_room(r.position, r.value);
				end
				CMD_REMOVE: begin
					if (r.position >= occupancy)
						want.status = ST_RANGE;
					else
						want.removed_value = take_out(r.position);
				end
				CMD_APPEND: begin
					if (full)
						want.status = ST_FULL;
					else
						make_room(occupancy, r.value);
				end
				default: begin
					if (full)
						want.status = ST_FULL;
					else
						make_room(0, r.value);
				end
			endcase
			want.count = 7'(occupancy);
			owed_rsp.push_back(want);
			if (want.status == ST_OK)
				n_ok++;
			else if (want.status == ST_RANGE)
				n_range++;
			else
				n_full++;
			if (r.cmd == CMD_REMOVE && want.status == ST_OK)
				n_removed++;
			if (occupancy > peak)
				peak = occupancy;
		endfunction

		function void check_response(resp_t got);
			resp_t want;
			if (owed_rsp.size() == 0) begin
				$error("response with nothing outstanding: status %0d removed_value %h count %0d",
					got.status, got.removed_value, got.count);
				errors++;
				return;
			end
			want = owed_rsp.pop_front();
			n_checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.removed_value !== want.removed_value) begin
				$error("removed_value: expected %h, actual %h", want.removed_value,
					got.removed_value);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	resp_t rsp;

	list_mirror mirror = new();

	// shared between the request and response sides
	bit steady;     // no idling on either side while set
	bit hold_rsp;   // asks the response side for one long stall

	indexed_list_insert_remove uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// reset held low from the start, released on a rising edge
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// response side: random back-pressure, one long stall on demand
	initial begin : rsp_side
		int unsigned hold_left;
		hold_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (steady) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// every response taken is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
			mirror.check_response(rsp);
	end

	// offer one request, with a random idle gap first, and note it once taken
	task automatic push_request(input req_t r);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_ready !== 1'b1)
			@(posedge clk);
		mirror.note_request(r);
	endtask

	task automatic push_fields(input logic [1:0] cmd, input logic [6:0] pos,
			input logic [31:0] val);
		req_t r;
		r.cmd      = cmd;
		r.position = pos;
		r.value    = val;
		push_request(r);
	endtask

	// random request shaped by the current trend: 0 grow, 1 shrink, 2 churn
	// most positions fall inside the list, a tenth are anywhere in the field
	function automatic req_t pick_request(int trend);
		req_t        r;
		int unsigned occ;
		int unsigned add_pct;
		int unsigned kind;
		occ     = mirror.occupancy;
		add_pct = (trend == 0) ? 80 : (trend == 1) ? 20 : 50;
		r.value = $urandom();
		case ($urandom_range(7))
			0: r.value = '0;
			1: r.value = '1;
			default: ;
		endcase
		if ($urandom_range(99) < add_pct) begin
			kind = $urandom_range(3);
			if (kind < 2)
				r.cmd = CMD_INSERT;
			else if (kind == 2)
				r.cmd = CMD_APPEND;
			else
				r.cmd = CMD_PREPEND;
		end else begin
			r.cmd = CMD_REMOVE;
		end
		r.position = 7'($urandom_range(127));
		if ($urandom_range(99) >= 10) begin
			if (r.cmd == CMD_REMOVE)
				r.position = (occ == 0) ? 7'd0 : 7'($urandom_range(occ - 1));
			else
				r.position = 7'($urandom_range(occ));
		end
		return r;
	endfunction

	initial begin : stimulus
		int unsigned done;
		int unsigned span;
		int          trend;
		int          phase;
		req_valid <= 1'b0;
		req       <= '0;
		steady    = 1'b0;
		hold_rsp  = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		@(posedge clk);

		// directed: empty list, both ends, edges of position and value
		push_fields(CMD_REMOVE,  7'd0,   32'h0000_0000);  // remove on empty
		push_fields(CMD_REMOVE,  7'd127, 32'hFFFF_FFFF);  // remove far out on empty
		push_fields(CMD_INSERT,  7'd1,   32'h1234_5678);  // insert past the end
		push_fields(CMD_INSERT,  7'd0,   32'hFFFF_FFFF);  // insert at front of empty
		push_fields(CMD_APPEND,  7'd0,   32'h0000_0000);
		push_fields(CMD_PREPEND, 7'd127, 32'hA5A5_A5A5);  // position ignored
		push_fields(CMD_INSERT,  7'd3,   32'h5A5A_5A5A);  // position equal to count appends
		push_fields(CMD_INSERT,  7'd1,   32'h0000_0001);
		push_fields(CMD_INSERT,  7'd127, 32'h8000_0000);  // far out of range
		push_fields(CMD_INSERT,  7'd64,  32'h7FFF_FFFF);
		push_fields(CMD_REMOVE,  7'd2,   32'hFFFF_FFFF);
		push_fields(CMD_REMOVE,  7'd4,   32'h0000_0000);  // remove at count
		push_fields(CMD_REMOVE,  7'd64,  32'h0000_0000);
		push_fields(CMD_REMOVE,  7'd0,   32'h0000_0000);
		push_fields(CMD_REMOVE,  7'd2,   32'h0000_0000);  // last entry
		push_fields(CMD_APPEND,  7'd127, 32'h8000_0000);
		push_fields(CMD_PREPEND, 7'd64,  32'h0F0F_0F0F);
		push_fields(CMD_INSERT,  7'd2,   32'hF0F0_F0F0);
		push_fields(CMD_REMOVE,  7'd1,   32'h0000_0000);
		push_fields(CMD_REMOVE,  7'd0,   32'h0000_0000);
		push_fields(CMD_REMOVE,  7'd0,   32'h0000_0000);
		push_fields(CMD_REMOVE,  7'd0,   32'h0000_0000);  // front remove, one entry left

		// random: phases of growth, shrinkage and churn, the first one growing
		done  = 0;
		phase = 0;
		while (done < N_RANDOM) begin
			trend = (phase == 0) ? 0 : $urandom_range(2);
			span  = $urandom_range(30, 120);
			for (int unsigned k = 0; k < span && done < N_RANDOM; k++) begin
				if (done == 500)
					hold_rsp = 1'b1;   // long stall while requests keep coming
				if (done == 900) begin
					// sender pause until every response is in
					req_valid <= 1'b0;
					while (mirror.owed_rsp.size() != 0)
						@(posedge clk);
				end
				steady = (done >= 1100 && done < 1300);
				push_request(pick_request(trend));
				done++;
			end
			phase++;
		end
		steady = 1'b0;
		req_valid <= 1'b0;

		while (mirror.owed_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d responses: %0d ok (%0d removes), %0d out of range, %0d list full",
			mirror.n_checked, mirror.n_ok, mirror.n_removed, mirror.n_range, mirror.n_full);
		$display("peak occupancy %0d of %0d, %0d mismatches", mirror.peak, CAP, mirror.errors);
		if (mirror.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== indexed_list_insert_remove.f =====
design/ilir_pkg.sv
design/ilir_cell.sv
design/ilir_ctrl.sv
design/indexed_list_insert_remove.sv
sim/tb_indexed_list_insert_remove.sv
